/* rtl/mvr_pkg.sv */
`timescale 1ns / 1ps

package mvr_pkg;

  localparam logic [7:0]  START_BYTE   = 8'hFE;
  localparam logic [15:0] CRC_SEED     = 16'hFFFF;
  localparam logic [7:0]  ID_HEARTBEAT = 8'd0;
  localparam logic [7:0]  ID_ACK       = 8'd77;
  localparam logic [7:0]  HB_EXTRA_RST  = 8'd50;
  localparam logic [7:0]  ACK_EXTRA_RST = 8'd143;
  localparam int unsigned HEAD_BYTES   = 3;

  // configuration register indexes
  localparam logic CFG_HB_EXTRA  = 1'b0;
  localparam logic CFG_ACK_EXTRA = 1'b1;

  typedef enum logic [1:0] {
    KIND_HEARTBEAT = 2'd0,
    KIND_ACK       = 2'd1,
    KIND_OTHER     = 2'd2
  } frame_kind_e;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic        crc_ok;
    logic [7:0]  message_id;
    logic [15:0] acked_command;
    logic [7:0]  ack_status;
  } mvr_frame_t;

  // one byte of the X.25 (reflected CCITT) CRC
  function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] v);
    logic [7:0] t;
    t = v ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

/* rtl/mvr_stream_if.sv */
`timescale 1ns / 1ps

interface mvr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mvr_frame_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_kind;
  logic        crc_ok;
  logic [7:0]  message_id;
  logic [15:0] acked_command;
  logic [7:0]  ack_status;

  modport source (output valid, output frame_kind, output crc_ok, output message_id,
                  output acked_command, output ack_status, input ready);
  modport sink (input valid, input frame_kind, input crc_ok, input message_id,
                input acked_command, input ack_status, output ready);
endinterface

/* rtl/mvr_parser.sv */
`timescale 1ns / 1ps

module mvr_parser
  import mvr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] hb_extra_i,
  input  logic [7:0] ack_extra_i,
  output logic       res_valid_o,
  output mvr_frame_t res_o
);

  typedef enum logic [3:0] {
    PH_STX, PH_LEN, PH_SEQ, PH_SYS, PH_COMP, PH_MSGID, PH_PAYLOAD, PH_CRC1, PH_CRC2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  msg_id_q, msg_id_d;
  logic [7:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [7:0]  head_q [HEAD_BYTES];
  logic [7:0]  head_d [HEAD_BYTES];

  logic [15:0] crc_upd;
  logic [15:0] crc_calc;
  logic [7:0]  extra;
  logic [1:0]  kind;

  assign crc_upd = x25_update(crc_q, rx_byte_i);

  always_comb begin
    if (msg_id_q == ID_HEARTBEAT) begin
      extra = hb_extra_i;
      kind  = KIND_HEARTBEAT;
    end else if (msg_id_q == ID_ACK) begin
      extra = ack_extra_i;
      kind  = KIND_ACK;
    end else begin
      extra = 8'h00;
      kind  = KIND_OTHER;
    end
  end

  assign crc_calc = x25_update(crc_q, extra);

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    msg_id_d = msg_id_q;
    idx_d    = idx_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    head_d   = head_q;
    res_valid_o = 1'b0;
    res_o.frame_kind    = kind;
    res_o.crc_ok        = (crc_calc == {rx_byte_i, crc_lo_q});
    res_o.message_id    = msg_id_q;
    res_o.acked_command = (kind == KIND_ACK) ? {head_q[1], head_q[0]} : 16'h0000;
    res_o.ack_status    = (kind == KIND_ACK) ? head_q[2] : 8'h00;
    if (step_i) begin
      unique case (phase_q)
        PH_STX: begin
          if (rx_byte_i == START_BYTE) begin
            crc_d   = CRC_SEED;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          crc_d   = crc_upd;
          len_d   = rx_byte_i;
          phase_d = PH_SEQ;
        end
        PH_SEQ: begin
          crc_d   = crc_upd;
          phase_d = PH_SYS;
        end
        PH_SYS: begin
          crc_d   = crc_upd;
          phase_d = PH_COMP;
        end
        PH_COMP: begin
          crc_d   = crc_upd;
          phase_d = PH_MSGID;
        end
        PH_MSGID: begin
          crc_d    = crc_upd;
          msg_id_d = rx_byte_i;
          idx_d    = 8'd0;
          phase_d  = (len_q != 8'd0) ? PH_PAYLOAD : PH_CRC1;
        end
        PH_PAYLOAD: begin
          crc_d = crc_upd;
          for (int i = 0; i < HEAD_BYTES; i++) begin
            if (idx_q == 8'(i)) head_d[i] = rx_byte_i;
          end
          idx_d = idx_q + 8'd1;
          if (idx_d >= len_q) phase_d = PH_CRC1;
        end
        PH_CRC1: begin
          crc_lo_d = rx_byte_i;
          phase_d  = PH_CRC2;
        end
        PH_CRC2: begin
          res_valid_o = 1'b1;
          phase_d     = PH_STX;
        end
        default: phase_d = PH_STX;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_STX;
      len_q    <= 8'd0;
      msg_id_q <= 8'd0;
      idx_q    <= 8'd0;
      crc_q    <= 16'h0000;
      crc_lo_q <= 8'd0;
      for (int i = 0; i < HEAD_BYTES; i++) head_q[i] <= 8'd0;
    end else begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      msg_id_q <= msg_id_d;
      idx_q    <= idx_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      head_q   <= head_d;
    end
  end

endmodule

/* rtl/mvr_out_reg.sv */
`timescale 1ns / 1ps

module mvr_out_reg
  import mvr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  mvr_frame_t data_i,
  output logic       free_o,
  mvr_frame_if.source frame_o
);

  logic       valid_q, valid_d;
  mvr_frame_t data_q;

  // slot can take a new request when empty or being drained this cycle
  assign free_o = !valid_q || frame_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (frame_o.ready) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= data_i;
  end

  assign frame_o.valid         = valid_q;
  assign frame_o.frame_kind    = data_q.frame_kind;
  assign frame_o.crc_ok        = data_q.crc_ok;
  assign frame_o.message_id    = data_q.message_id;
  assign frame_o.acked_command = data_q.acked_command;
  assign frame_o.ack_status    = data_q.ack_status;

endmodule

/* rtl/mavlink_v1_frame_receiver.sv */
`timescale 1ns / 1ps
// The byte lands in the input register at accept; the parser step then loads the
// result register once the result slot is free. Throughput: one byte per cycle
// while the output is not stalled; the byte-wise CRC and phase update is one step.
// Reset (async, active low): parser waits for the start byte, kept payload bytes
// clear to zero, CRC extras return to 50 (heartbeat) and 143 (command ack).
module mavlink_v1_frame_receiver
  import mvr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  mvr_byte_if.sink    rx_i,
  mvr_frame_if.source frame_o
);

  logic [7:0] hb_extra_r;
  logic [7:0] ack_extra_r;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_free;
  logic       advance;
  logic       res_valid;
  mvr_frame_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_extra_r  <= HB_EXTRA_RST;
      ack_extra_r <= ACK_EXTRA_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HB_EXTRA:  hb_extra_r  <= cfg_data_i;
        CFG_ACK_EXTRA: ack_extra_r <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance    = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) in_byte_q <= rx_i.rx_byte;
  end

  mvr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .rx_byte_i   (in_byte_q),
    .hb_extra_i  (hb_extra_r),
    .ack_extra_i (ack_extra_r),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mvr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .data_i  (res),
    .free_o  (out_free),
    .frame_o (frame_o)
  );

  a_no_kind3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid |-> (frame_o.frame_kind != 2'd3))
    else $error("invalid frame kind on result");

  a_non_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_o.valid && (frame_o.frame_kind != KIND_ACK)) |->
      (frame_o.acked_command == 16'h0000 && frame_o.ack_status == 8'h00))
    else $error("ack fields not cleared on non-ack frame");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> (in_valid_q && frame_o.valid && !frame_o.ready))
    else $error("input stalled without a stalled result");

  a_kind_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_o.valid && frame_o.message_id == ID_ACK) |-> (frame_o.frame_kind == KIND_ACK))
    else $error("kind does not match message id");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import mvr_pkg::*;

  typedef enum logic [3:0] {
    WAIT_STX,
    GET_LEN,
    GET_SEQ,
    GET_SYS,
    GET_COMP,
    GET_MSGID,
    GET_PAYLOAD,
    GET_CRC_LO,
    GET_CRC_HI
  } rx_phase_e;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  mvr_byte_if  byte_if ();
  mvr_frame_if frame_if ();

  mavlink_v1_frame_receiver DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .rx_i       (byte_if.sink),
    .frame_o    (frame_if.source)
  );

  // bytes waiting for the driver, frames waiting for the monitor
  logic [7:0] pending_bytes[$];
  mvr_frame_t expected_frames[$];
  int unsigned mismatches = 0;
  int unsigned frame_bytes_queued = 0;

  // parser copy
  logic [7:0] hb_extra = HB_EXTRA_RST;
  logic [7:0] ack_extra = ACK_EXTRA_RST;
  rx_phase_e  rx_phase = WAIT_STX;
  logic [7:0] rx_len = '0;
  logic [7:0] rx_msg_id = '0;
  logic [7:0] rx_index = '0;
  logic [15:0] rx_crc = '0;
  logic [7:0] rx_crc_lo = '0;
  logic [7:0] rx_head[3] = '{8'h00, 8'h00, 8'h00};

  // sender pacing
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  // receiver stall pattern
  logic [15:0] stall_cycle;
  logic [1:0]  stall_mode;

  // reflected CCITT, polynomial 0x8408, one bit at a time
  function automatic logic [15:0] x25_crc_byte(input logic [15:0] crc, input logic [7:0] v);
    logic [15:0] c;
    c = crc ^ {8'h00, v};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    mvr_frame_t res;
    logic [7:0] extra;
    case (rx_phase)
      WAIT_STX: begin
        if (b == START_BYTE) begin
          rx_crc = CRC_SEED;
          rx_phase = GET_LEN;
        end
      end
      GET_LEN: begin
        rx_crc = x25_crc_byte(rx_crc, b);
        rx_len = b;
        rx_phase = GET_SEQ;
      end
      GET_SEQ, GET_SYS, GET_COMP: begin
        rx_crc = x25_crc_byte(rx_crc, b);
        rx_phase = rx_phase_e'(rx_phase + 1);
      end
      GET_MSGID: begin
        rx_crc = x25_crc_byte(rx_crc, b);
        rx_msg_id = b;
        rx_index = '0;
        rx_phase = (rx_len != 0) ? GET_PAYLOAD : GET_CRC_LO;
      end
      GET_PAYLOAD: begin
        rx_crc = x25_crc_byte(rx_crc, b);
        if (rx_index < HEAD_BYTES) rx_head[rx_index[1:0]] = b;
        rx_index = rx_index + 8'd1;
        if (rx_index >= rx_len) rx_phase = GET_CRC_LO;
      end
      GET_CRC_LO: begin
        rx_crc_lo = b;
        rx_phase = GET_CRC_HI;
      end
      default: begin
        res = '0;
        if (rx_msg_id == ID_HEARTBEAT) begin
          extra = hb_extra;
          res.frame_kind = KIND_HEARTBEAT;
        end else if (rx_msg_id == ID_ACK) begin
          extra = ack_extra;
          res.frame_kind = KIND_ACK;
        end else begin
          extra = 8'h00;
          res.frame_kind = KIND_OTHER;
        end
        res.crc_ok = (x25_crc_byte(rx_crc, extra) == {b, rx_crc_lo});
        res.message_id = rx_msg_id;
        if (res.frame_kind == KIND_ACK) begin
          res.acked_command = {rx_head[1], rx_head[0]};
          res.ack_status = rx_head[2];
        end
        expected_frames.push_back(res);
        rx_phase = WAIT_STX;
      end
    endcase
  endtask

  task automatic check_frame();
    mvr_frame_t want;
    if (expected_frames.size() == 0) begin
      report_mismatch("frame with none expected, id", frame_if.message_id, 0);
    end else begin
      want = expected_frames.pop_front();
      if (frame_if.frame_kind !== want.frame_kind)
        report_mismatch("frame_kind", frame_if.frame_kind, want.frame_kind);
      if (frame_if.crc_ok !== want.crc_ok)
        report_mismatch("crc_ok", frame_if.crc_ok, want.crc_ok);
      if (frame_if.message_id !== want.message_id)
        report_mismatch("message_id", frame_if.message_id, want.message_id);
      if (frame_if.acked_command !== want.acked_command)
        report_mismatch("acked_command", frame_if.acked_command, want.acked_command);
      if (frame_if.ack_status !== want.ack_status)
        report_mismatch("ack_status", frame_if.ack_status, want.ack_status);
    end
  endtask

  // fill < 0: random payload; cut < 0: whole frame, else only the first cut bytes
  task automatic queue_frame(input logic [7:0] id, input int len, input int fill,
                             input bit corrupt, input int cut);
    logic [7:0]  frame_bytes[$];
    logic [15:0] crc;
    logic [7:0]  extra;
    logic [7:0]  pb;
    frame_bytes = {START_BYTE, len[7:0]};
    repeat (3) frame_bytes.push_back(8'($urandom_range(0, 255)));
    frame_bytes.push_back(id);
    for (int k = 0; k < len; k++) begin
      if (fill >= 0) pb = fill[7:0];
      else if ($urandom_range(0, 7) == 0) pb = START_BYTE;
      else pb = 8'($urandom_range(0, 255));
      frame_bytes.push_back(pb);
    end
    crc = CRC_SEED;
    for (int k = 1; k < frame_bytes.size(); k++) crc = x25_crc_byte(crc, frame_bytes[k]);
    if (id == ID_HEARTBEAT) extra = hb_extra;
    else if (id == ID_ACK) extra = ack_extra;
    else extra = 8'h00;
    crc = x25_crc_byte(crc, extra);
    if (corrupt) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    for (int k = 0; k < frame_bytes.size() && (cut < 0 || k < cut); k++) begin
      pending_bytes.push_back(frame_bytes[k]);
      frame_bytes_queued++;
    end
  endtask

  task automatic queue_noise(input int count);
    logic [7:0] b;
    repeat (count) begin
      b = 8'($urandom_range(0, 255));
      if (b == START_BYTE) b = 8'h00;
      pending_bytes.push_back(b);
    end
  endtask

  task automatic run_random_frames(input int unsigned byte_budget);
    int unsigned stop_at;
    logic [7:0] id;
    int len;
    int r;
    stop_at = frame_bytes_queued + byte_budget;
    while (frame_bytes_queued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 35) id = ID_HEARTBEAT;
      else if (r < 70) id = ID_ACK;
      else id = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(0, 6);
      else if (r < 98) len = $urandom_range(7, 20);
      else len = $urandom_range(128, 255);
      if ($urandom_range(0, 4) == 0) queue_noise($urandom_range(1, 4));
      // a cut frame leaves the parser mid-frame, so the next frames are misframed
      queue_frame(id, len, -1, $urandom_range(0, 4) == 0,
                  ($urandom_range(0, 19) == 0) ? $urandom_range(1, len + 7) : -1);
    end
  endtask

  // idle: nothing left to send, nothing outstanding, parser has caught up
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || byte_if.valid || expected_frames.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_crc_extras(input logic [7:0] hb, input logic [7:0] ack);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_HB_EXTRA;
    cfg_data <= hb;
    hb_extra = hb;
    @(posedge clk);
    cfg_index <= CFG_ACK_EXTRA;
    cfg_data <= ack;
    ack_extra = ack;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sender: bursts of random length, random gaps between them
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      byte_if.valid <= 1'b0;
      byte_if.rx_byte <= 8'h00;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (byte_if.valid && byte_if.ready) parse_rx_byte(byte_if.rx_byte);
      if (byte_if.valid && !byte_if.ready) begin
        // hold the request until taken
      end else if (gap_left != 0) begin
        byte_if.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_bytes.size() != 0) begin
        byte_if.valid <= 1'b1;
        byte_if.rx_byte <= pending_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                    : $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  // receiver: stall mode is redrawn at random whenever stall_cycle[5:0] wraps
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      frame_if.ready <= 1'b0;
      stall_cycle <= '0;
      stall_mode <= '0;
    end else begin
      if (frame_if.valid && frame_if.ready) check_frame();
      stall_cycle <= stall_cycle + 16'd1;
      if (stall_cycle[5:0] == 6'd63) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0:    frame_if.ready <= 1'b1;
        2'd1:    frame_if.ready <= (stall_cycle[1:0] == 2'd0);
        2'd2:    frame_if.ready <= 1'($urandom_range(0, 1));
        default: frame_if.ready <= (stall_cycle[5:4] == 2'd3);
      endcase
    end
  end

  initial begin
    logic [7:0] hb;
    logic [7:0] ack;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_HB_EXTRA;
    cfg_data = 8'h00;
    byte_if.valid = 1'b0;
    byte_if.rx_byte = 8'h00;
    frame_if.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset extras
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h55);
    queue_frame(ID_HEARTBEAT, 9, -1, 1'b0, -1);
    queue_frame(ID_ACK, 3, 8'hFF, 1'b0, -1);
    queue_frame(ID_ACK, 0, -1, 1'b0, -1);           // kept bytes all stale
    queue_frame(ID_ACK, 1, 8'h00, 1'b1, -1);        // bad CRC, bytes 1..2 stale
    queue_frame(8'hFF, 5, START_BYTE, 1'b0, -1);    // start byte inside payload
    queue_frame(START_BYTE, 2, -1, 1'b1, -1);
    queue_frame(ID_HEARTBEAT, 0, -1, 1'b1, -1);
    queue_frame(ID_ACK, 255, -1, 1'b0, -1);
    wait_drained();

    for (int phase_no = 1; phase_no <= 5; phase_no++) begin
      case (phase_no)
        1: begin hb = 8'h00; ack = 8'hFF; end
        2: begin hb = 8'hFF; ack = 8'h00; end
        4: begin hb = HB_EXTRA_RST; ack = ACK_EXTRA_RST; end
        default: begin
          hb = 8'($urandom_range(0, 255));
          ack = 8'($urandom_range(0, 255));
        end
      endcase
      set_crc_extras(hb, ack);
      run_random_frames(100);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("** mavlink_v1_frame_receiver: PASSED **");
    end else begin
      $display("** mavlink_v1_frame_receiver: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** mavlink_v1_frame_receiver: FAILED **");
    $finish;
  end

endmodule
